/* sv/tmv_pkg.sv */
`timescale 1ns / 1ps

package tmv_pkg;

  localparam int MAX_COLUMNS_DEF = 4096;

  localparam int SUM_W  = 20;
  localparam int ROW_W  = 16;
  localparam int COLS_W = 13;
  localparam int CFG_W  = 16;
  localparam int ACT_W  = 8;
  localparam int IDX_W  = 12;
  localparam int BYTE_W = 8;

  localparam logic [COLS_W-1:0] COLS_RESET = 13'd4096;
  localparam logic [ROW_W-1:0]  ROWS_RESET = 16'd1;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  localparam logic [1:0] CODE_SUB  = 2'd0;
  localparam logic [1:0] CODE_ADD  = 2'd2;
  localparam logic [1:0] CODE_LAST = 2'd3;

  typedef struct packed {
    logic [1:0]       code;
    logic             row_end;
    logic             fin;
    logic             last;
    logic [ROW_W-1:0] row;
  } tmv_acc_t;

endpackage

/* sv/ternary_int8_matvec.sv */
`timescale 1ns / 1ps

// Load item: written straight into the activation store when accepted.
// Weight byte: up to four store reads, one per code (fewer at the matrix end), and no new
// byte is taken until the last; a row result goes via the read register to the output register.
// The single-port activation store serializes the reads; a stalled output holds the pipeline.
// Reset clears the column, row and sum counters and restores the configuration
// registers; the activation store is not cleared and holds nothing defined until loaded.
module ternary_int8_matvec #(
  parameter int MAX_COLUMNS = tmv_pkg::MAX_COLUMNS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [tmv_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [tmv_pkg::IDX_W-1:0]         act_index_i,
  input  logic signed [tmv_pkg::ACT_W-1:0]  act_value_i,
  input  logic [tmv_pkg::BYTE_W-1:0]        weight_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tmv_pkg::SUM_W-1:0]  row_sum_o,
  output logic [tmv_pkg::ROW_W-1:0]         row_number_o,
  output logic                              final_row_o,
  output logic                              last_o
);

  localparam int AW = $clog2(MAX_COLUMNS);
  localparam int XW = (AW > tmv_pkg::IDX_W) ? AW + 1 : tmv_pkg::IDX_W + 1;
  localparam int EW = (AW + 1 > tmv_pkg::COLS_W) ? AW + 1 : tmv_pkg::COLS_W;
  localparam int SW = tmv_pkg::SUM_W;
  localparam int RW = tmv_pkg::ROW_W;

  logic [tmv_pkg::COLS_W-1:0] cols_q;
  logic [RW-1:0]              rows_q;

  logic signed [tmv_pkg::ACT_W-1:0] act_mem_q [MAX_COLUMNS];
  logic signed [tmv_pkg::ACT_W-1:0] rd_q;

  logic                       busy_q, busy_d;
  logic [1:0]                 idx_q, idx_d;
  logic [tmv_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic [AW-1:0]              col_q, col_d;
  logic [RW-1:0]              row_q, row_d;

  logic              acc_v_q, acc_v_d;
  tmv_pkg::tmv_acc_t acc_q, acc_d;
  logic signed [SW-1:0] sum_q, sum_d;

  logic                 out_v_q, out_v_d;
  logic signed [SW-1:0] out_sum_q;
  logic [RW-1:0]        out_row_q;
  logic                 out_fin_q;
  logic                 out_last_q;

  logic          accept, blocked, issue, acc_go;
  logic          ld_ok, mem_we;
  logic [XW-1:0] ld_idx_x;
  logic [AW-1:0] mem_addr;
  logic [EW-1:0] eff_cols, cols_x;
  logic [AW:0]   col_inc;
  logic          col_end;
  logic [RW:0]   row_inc, eff_rows;
  logic          fin;
  logic signed [SW:0] sum_ext, act_ext, sum_raw;
  logic signed [SW-1:0] sum_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tmv_pkg::COLS_RESET;
      rows_q <= tmv_pkg::ROWS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tmv_pkg::CFG_COLUMNS) begin
        cols_q <= cfg_wdata_i[tmv_pkg::COLS_W-1:0];
      end else begin
        rows_q <= cfg_wdata_i[RW-1:0];
      end
    end
  end

  always_comb begin
    cols_x = EW'(cols_q);
    if (cols_x == '0) begin
      eff_cols = EW'(1);
    end else if (cols_x > EW'(MAX_COLUMNS)) begin
      eff_cols = EW'(MAX_COLUMNS);
    end else begin
      eff_cols = cols_x;
    end
    eff_rows = (rows_q == '0) ? (RW+1)'(1) : {1'b0, rows_q};
  end

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i & ~busy_q;
  assign blocked    = acc_v_q & acc_q.row_end & out_v_q & out_stall_i;
  assign issue      = busy_q & ~blocked;
  assign acc_go     = acc_v_q & ~blocked;

  assign ld_idx_x = XW'(act_index_i);
  assign ld_ok    = ld_idx_x < XW'(MAX_COLUMNS);
  assign mem_we   = accept & (operation_i == tmv_pkg::OP_LOAD) & ld_ok;
  assign mem_addr = mem_we ? ld_idx_x[AW-1:0] : col_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      act_mem_q[mem_addr] <= act_value_i;
    end
    if (issue) begin
      rd_q <= act_mem_q[mem_addr];
    end
  end

  assign col_inc = {1'b0, col_q} + (AW+1)'(1);
  assign col_end = EW'(col_inc) >= eff_cols;
  assign row_inc = {1'b0, row_q} + (RW+1)'(1);
  assign fin     = col_end & (row_inc >= eff_rows);

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    byte_d  = byte_q;
    col_d   = col_q;
    row_d   = row_q;
    acc_v_d = acc_v_q;
    acc_d   = acc_q;
    if (accept && operation_i == tmv_pkg::OP_WEIGHT) begin
      busy_d = 1'b1;
      idx_d  = '0;
      byte_d = weight_byte_i;
    end
    if (issue) begin
      acc_v_d       = 1'b1;
      acc_d.code    = byte_q[7:6];
      acc_d.row_end = col_end;
      acc_d.fin     = fin;
      acc_d.last    = fin | (eff_cols > EW'(tmv_pkg::CODE_LAST - idx_q));
      acc_d.row     = row_q;
      byte_d        = {byte_q[5:0], 2'b00};
      idx_d         = idx_q + 2'd1;
      if (col_end) begin
        col_d = '0;
        row_d = fin ? '0 : row_inc[RW-1:0];
      end else begin
        col_d = col_inc[AW-1:0];
      end
      if (fin || idx_q == tmv_pkg::CODE_LAST) begin
        busy_d = 1'b0;
      end
    end else if (!blocked) begin
      acc_v_d = 1'b0;
    end
  end

  always_comb begin
    sum_ext = {sum_q[SW-1], sum_q};
    act_ext = (SW+1)'(rd_q);
    case (acc_q.code)
      tmv_pkg::CODE_ADD: sum_raw = sum_ext + act_ext;
      tmv_pkg::CODE_SUB: sum_raw = sum_ext - act_ext;
      default:           sum_raw = sum_ext;
    endcase
    if (sum_raw[SW] != sum_raw[SW-1]) begin
      sum_sat = sum_raw[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_raw[SW-1:0];
    end
    sum_d = sum_q;
    if (acc_go) begin
      sum_d = acc_q.row_end ? '0 : sum_sat;
    end
    out_v_d = out_v_q;
    if (acc_go && acc_q.row_end) begin
      out_v_d = 1'b1;
    end else if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      acc_v_q <= 1'b0;
      sum_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      row_q   <= row_d;
      acc_v_q <= acc_v_d;
      sum_q   <= sum_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    acc_q  <= acc_d;
    if (acc_go && acc_q.row_end) begin
      out_sum_q  <= sum_sat;
      out_row_q  <= acc_q.row;
      out_fin_q  <= acc_q.fin;
      out_last_q <= acc_q.last;
    end
  end

  assign out_valid_o  = out_v_q;
  assign row_sum_o    = out_sum_q;
  assign row_number_o = out_row_q;
  assign final_row_o  = out_fin_q;
  assign last_o       = out_last_q;

endmodule
